// ===== sv/eic64_pkg.sv =====
package eic64_pkg;

  // bank geometry
  localparam int NUM_BANKS  = 2;
  localparam int BANK_W     = 32;
  localparam int BANK_IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  // request commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // register kind, upper two bits of reg_sel
  typedef enum logic [1:0] {
    KIND_ENABLE   = 2'd0,
    KIND_POLARITY = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_t;

  typedef logic [BANK_W-1:0] word_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  reg_sel;
    logic [31:0] write_data;
    logic [31:0] levels_lo;
    logic [31:0] levels_hi;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
  } res_t;

endpackage

// ===== sv/edge_interrupt_controller_64_top.sv =====
// Edge-triggered interrupt controller for 64 sources in two 32-bit banks. Each request is
// either a tick carrying the current source levels, a register read or a register write;
// every request produces exactly one result carrying read_data (zero unless it was a valid
// read) and irq_out, the OR of all status bits after that request. The state update and the
// result are computed from the request port and the state registers in a single pass and
// land in the result register, so one request per cycle is sustained while the skid register
// is empty. A two-entry result buffer (result register plus skid register) lets a request be
// taken while the previous result is still held by res_stall; req_stall is driven only from
// the skid register, so there is no combinational path from res_stall. Each result is
// registered in the output or the skid register. Register map by reg_sel: 0/1 enable
// lo/hi, 2/3 polarity lo/hi (0 rising, 1 falling), 4/5 status lo/hi (write ones to clear);
// 6 and 7 read as zero and ignore writes. Writing polarity on an enabled source whose
// effective level rises as a result sets its status. Command 3 changes nothing.
module edge_interrupt_controller_64_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  eic64_pkg::req_t  req,
  output logic             res_valid,
  input  logic             res_stall,
  output eic64_pkg::res_t  res
);

  // per-bank state
  eic64_pkg::word_t enable   [eic64_pkg::NUM_BANKS];
  eic64_pkg::word_t polarity [eic64_pkg::NUM_BANKS];
  eic64_pkg::word_t status   [eic64_pkg::NUM_BANKS];
  eic64_pkg::word_t prev_eff [eic64_pkg::NUM_BANKS];

  eic64_pkg::word_t enable_next   [eic64_pkg::NUM_BANKS];
  eic64_pkg::word_t polarity_next [eic64_pkg::NUM_BANKS];
  eic64_pkg::word_t status_next   [eic64_pkg::NUM_BANKS];
  eic64_pkg::word_t prev_eff_next [eic64_pkg::NUM_BANKS];

  // result buffer: output register and skid register
  eic64_pkg::res_t skid;
  logic            skid_valid;
  eic64_pkg::res_t result_next;

  logic accept;
  logic res_fire;
  logic any_pending;

  // request decode
  logic [1:0]                      kind;
  logic [eic64_pkg::BANK_IDX_W-1:0] bank;
  logic                            sel_ok;

  assign req_stall = skid_valid;
  assign accept    = req_valid & ~req_stall;
  assign res_fire  = res_valid & ~res_stall;

  assign kind   = req.reg_sel[2:1];
  assign bank   = eic64_pkg::BANK_IDX_W'(req.reg_sel[0]);
  // reserved kind or a bank that is not built
  assign sel_ok = (kind != 2'd3) && (32'(req.reg_sel[0]) < eic64_pkg::NUM_BANKS);

  // single pass: state update and result for the request on the port
  always_comb begin
    eic64_pkg::word_t lv;
    eic64_pkg::word_t eff;
    logic             irq;
    lv  = '0;
    eff = '0;
    irq = 1'b0;
    for (int b = 0; b < eic64_pkg::NUM_BANKS; b++) begin
      enable_next[b]   = enable[b];
      polarity_next[b] = polarity[b];
      status_next[b]   = status[b];
      prev_eff_next[b] = prev_eff[b];
    end
    result_next.read_data = '0;

    unique case (req.cmd)
      eic64_pkg::CMD_TICK: begin
        // only the two lowest banks have level inputs
        for (int b = 0; b < eic64_pkg::NUM_BANKS; b++) begin
          lv = (b == 0) ? req.levels_lo : ((b == 1) ? req.levels_hi : '0);
          eff = lv ^ polarity[b];
          status_next[b]   = status[b] | (eff & ~prev_eff[b] & enable[b]);
          prev_eff_next[b] = eff;
        end
      end
      eic64_pkg::CMD_READ: begin
        if (sel_ok) begin
          unique case (kind)
            eic64_pkg::KIND_ENABLE:   result_next.read_data = enable[bank];
            eic64_pkg::KIND_POLARITY: result_next.read_data = polarity[bank];
            eic64_pkg::KIND_STATUS:   result_next.read_data = status[bank];
            default:                  result_next.read_data = '0;
          endcase
        end
      end
      eic64_pkg::CMD_WRITE: begin
        if (sel_ok) begin
          unique case (kind)
            eic64_pkg::KIND_ENABLE: enable_next[bank] = req.write_data;
            eic64_pkg::KIND_POLARITY: begin
              // raw level is prev_eff ^ old polarity; re-apply with the new polarity
              eff = prev_eff[bank] ^ polarity[bank] ^ req.write_data;
              polarity_next[bank] = req.write_data;
              status_next[bank]   = status[bank] | (eff & ~prev_eff[bank] & enable[bank]);
              prev_eff_next[bank] = eff;
            end
            eic64_pkg::KIND_STATUS: status_next[bank] = status[bank] & ~req.write_data;
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    for (int b = 0; b < eic64_pkg::NUM_BANKS; b++) begin
      irq = irq | (|status_next[b]);
    end
    result_next.irq_out = irq;
  end

  // state registers, updated only when a request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < eic64_pkg::NUM_BANKS; b++) begin
        enable[b]   <= '0;
        polarity[b] <= '0;
        status[b]   <= '0;
        prev_eff[b] <= '0;
      end
    end else if (accept) begin
      for (int b = 0; b < eic64_pkg::NUM_BANKS; b++) begin
        enable[b]   <= enable_next[b];
        polarity[b] <= polarity_next[b];
        status[b]   <= status_next[b];
        prev_eff[b] <= prev_eff_next[b];
      end
    end
  end

  // result register with skid; a request is only taken while the skid is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!res_valid || res_fire) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (res_fire) begin
      res_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // payload of the result buffer, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!res_valid || res_fire) begin
        res <= result_next;
      end else begin
        skid <= result_next;
      end
    end else if (res_fire && skid_valid) begin
      res <= skid;
    end
  end

  // live OR of all status bits
  always_comb begin
    any_pending = 1'b0;
    for (int b = 0; b < eic64_pkg::NUM_BANKS; b++) begin
      any_pending = any_pending | (|status[b]);
    end
  end

  // skid is only ever occupied behind a held result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a result while the output register is empty");

  // a result loaded straight into the output register reports the new status OR
  a_irq_matches_status: assert property (@(posedge clk) disable iff (rst)
    accept && (!res_valid || res_fire) |=> res.irq_out == any_pending)
    else $error("irq_out does not match the status registers");

  // a tick never sets status on a disabled source in bank 0
  a_tick_needs_enable: assert property (@(posedge clk) disable iff (rst)
    accept && req.cmd == eic64_pkg::CMD_TICK
    |=> (status[0] & ~$past(status[0]) & ~$past(enable[0])) == '0)
    else $error("status set on a disabled source");

  // reads leave the bank 0 enable, status and prev_eff state untouched
  a_read_no_side_effect: assert property (@(posedge clk) disable iff (rst)
    accept && req.cmd == eic64_pkg::CMD_READ
    |=> $stable(status[0]) && $stable(prev_eff[0]) && $stable(enable[0]))
    else $error("register read changed state");

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !skid_valid)
    else $error("result buffer not empty after reset");

endmodule

// ===== verif/eic64_irq_checker.sv =====
module eic64_irq_checker
  import eic64_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic res_valid,
  input  logic res_stall,
  input  res_t res,
  output int   mismatches,
  output int   awaited
);

  word_t enable_q   [NUM_BANKS];
  word_t polarity_q [NUM_BANKS];
  word_t status_q   [NUM_BANKS];
  word_t eff_level_q[NUM_BANKS];

  res_t awaited_res[$];

  // enabled sources whose effective level goes 0 to 1 latch their status
  function automatic void latch_rising(int b, word_t eff);
    status_q[b]    = status_q[b] | (eff & ~eff_level_q[b] & enable_q[b]);
    eff_level_q[b] = eff;
  endfunction

  function automatic res_t next_irq_result(req_t r);
    res_t        out;
    word_t       lv;
    word_t       raw;
    int unsigned bank;
    int          b;
    out  = '0;
    bank = r.reg_sel[0];
    case (r.cmd)
      CMD_TICK: begin
        for (b = 0; b < NUM_BANKS; b++) begin
          lv = (b == 0) ? r.levels_lo : ((b == 1) ? r.levels_hi : '0);
          latch_rising(b, lv ^ polarity_q[b]);
        end
      end
      CMD_READ: begin
        if (bank < NUM_BANKS) begin
          case (r.reg_sel[2:1])
            KIND_ENABLE:   out.read_data = enable_q[bank];
            KIND_POLARITY: out.read_data = polarity_q[bank];
            KIND_STATUS:   out.read_data = status_q[bank];
            default:       out.read_data = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (bank < NUM_BANKS) begin
          case (r.reg_sel[2:1])
            KIND_ENABLE: enable_q[bank] = r.write_data;
            KIND_POLARITY: begin
              // raw level comes back out of the old polarity
              raw = eff_level_q[bank] ^ polarity_q[bank];
              polarity_q[bank] = r.write_data;
              latch_rising(bank, raw ^ r.write_data);
            end
            KIND_STATUS: status_q[bank] = status_q[bank] & ~r.write_data;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    out.irq_out = 1'b0;
    for (b = 0; b < NUM_BANKS; b++) begin
      if (status_q[b] != '0) out.irq_out = 1'b1;
    end
    return out;
  endfunction

  always @(posedge clk) begin
    res_t want;
    int   b;
    if (rst) begin
      for (b = 0; b < NUM_BANKS; b++) begin
        enable_q[b]    = '0;
        polarity_q[b]  = '0;
        status_q[b]    = '0;
        eff_level_q[b] = '0;
      end
      awaited_res.delete();
      mismatches = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited_res.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual %h", $time, res);
        end else begin
          want = awaited_res.pop_front();
          if (res.read_data !== want.read_data) begin
            mismatches++;
            $display("%0t read_data mismatch: expected %h, actual %h",
                     $time, want.read_data, res.read_data);
          end
          if (res.irq_out !== want.irq_out) begin
            mismatches++;
            $display("%0t irq_out mismatch: expected %b, actual %b",
                     $time, want.irq_out, res.irq_out);
          end
        end
      end
      if (req_valid && !req_stall) awaited_res.push_back(next_irq_result(req));
    end
    awaited <= awaited_res.size();
  end

endmodule

// ===== verif/edge_interrupt_controller_64_top_tb.sv =====
module edge_interrupt_controller_64_top_tb;
  import eic64_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_RSVD  = 2'd3;
  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam logic       BANK_LO   = 1'b0;
  localparam logic       BANK_HI   = 1'b1;
  localparam word_t      ALL_ONES  = '1;

  localparam int ITEMS_PER_PHASE = 500;
  localparam int CYCLE_LIMIT     = 300000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  int mismatches;
  int awaited;
  int cycles = 0;

  // idle chances in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // last source levels driven on a tick, so random ticks can wiggle a few bits
  word_t cur_lo = '0;
  word_t cur_hi = '0;

  edge_interrupt_controller_64_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  eic64_irq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop in case the handshake hangs or results never show up
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic req_t request_of(logic [1:0] cmd, logic [1:0] kind, logic bank,
                                      word_t wdata, word_t lo, word_t hi);
    req_t r;
    r.cmd        = cmd;
    r.reg_sel    = {kind, bank};
    r.write_data = wdata;
    r.levels_lo  = lo;
    r.levels_hi  = hi;
    return r;
  endfunction

  // mostly well-formed register traffic and ticks with slowly moving levels,
  // plus reserved selectors and the reserved command as noise
  function automatic req_t random_request();
    req_t       r;
    int         pick;
    logic [1:0] kind;
    pick         = $urandom_range(99);
    kind         = kind_t'($urandom_range(2));
    r.reg_sel    = {kind, 1'($urandom_range(1))};
    r.write_data = $urandom;
    r.levels_lo  = $urandom;
    r.levels_hi  = $urandom;
    if ($urandom_range(9) == 0) r.reg_sel = {KIND_RSVD, 1'($urandom_range(1))};
    if (pick < 45) begin
      r.cmd = CMD_TICK;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          // sparse toggles give isolated edges in both directions
          cur_lo ^= $urandom & $urandom & $urandom;
          cur_hi ^= $urandom & $urandom & $urandom;
        end
        6, 7: begin
          cur_lo = $urandom;
          cur_hi = $urandom;
        end
        default: ;
      endcase
      r.levels_lo = cur_lo;
      r.levels_hi = cur_hi;
    end else if (pick < 70) begin
      r.cmd = CMD_READ;
    end else if (pick < 95) begin
      r.cmd = CMD_WRITE;
      // keep most sources enabled so status bits actually latch
      if (r.reg_sel[2:1] == KIND_ENABLE && $urandom_range(1) == 0) r.write_data = ALL_ONES;
      if (r.reg_sel[2:1] == KIND_STATUS && $urandom_range(3) == 0) r.write_data = ALL_ONES;
    end else begin
      r.cmd = CMD_RSVD;
    end
    return r;
  endfunction

  // one request: idle cycles drawn one at a time, then hold it until it is taken
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin
    int ph;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, no idling
    // reset values read back as zero
    send_request(request_of(CMD_READ, KIND_ENABLE, BANK_LO, '0, '0, '0));
    send_request(request_of(CMD_READ, KIND_STATUS, BANK_HI, '0, '0, '0));
    // levels go high while disabled: tracked, nothing latched
    send_request(request_of(CMD_TICK, KIND_ENABLE, BANK_LO, '0, ALL_ONES, ALL_ONES));
    send_request(request_of(CMD_WRITE, KIND_ENABLE, BANK_LO, ALL_ONES, '0, '0));
    send_request(request_of(CMD_WRITE, KIND_ENABLE, BANK_HI, ALL_ONES, '0, '0));
    // level already high, so no edge after enabling
    send_request(request_of(CMD_TICK, KIND_ENABLE, BANK_LO, '0, ALL_ONES, ALL_ONES));
    send_request(request_of(CMD_TICK, KIND_ENABLE, BANK_LO, ALL_ONES, '0, '0));
    // every source rises at once
    send_request(request_of(CMD_TICK, KIND_ENABLE, BANK_LO, '0, ALL_ONES, ALL_ONES));
    send_request(request_of(CMD_READ, KIND_STATUS, BANK_LO, '0, '0, '0));
    send_request(request_of(CMD_READ, KIND_STATUS, BANK_HI, '0, '0, '0));
    // write-one-to-clear, then a write of zeros that clears nothing
    send_request(request_of(CMD_WRITE, KIND_STATUS, BANK_LO, ALL_ONES, '0, '0));
    send_request(request_of(CMD_WRITE, KIND_STATUS, BANK_HI, '0, '0, '0));
    send_request(request_of(CMD_READ, KIND_STATUS, BANK_HI, '0, '0, '0));
    send_request(request_of(CMD_WRITE, KIND_STATUS, BANK_HI, ALL_ONES, '0, '0));
    // falling polarity on high levels: effective level drops, no edge
    send_request(request_of(CMD_WRITE, KIND_POLARITY, BANK_HI, ALL_ONES, '0, '0));
    // falling edge on the high bank now latches
    send_request(request_of(CMD_TICK, KIND_ENABLE, BANK_LO, '0, ALL_ONES, '0));
    send_request(request_of(CMD_READ, KIND_POLARITY, BANK_HI, '0, '0, '0));
    send_request(request_of(CMD_WRITE, KIND_STATUS, BANK_HI, ALL_ONES, '0, '0));
    // polarity flip away and back on an enabled high source raises status
    send_request(request_of(CMD_WRITE, KIND_POLARITY, BANK_LO, ALL_ONES, '0, '0));
    send_request(request_of(CMD_WRITE, KIND_POLARITY, BANK_LO, '0, '0, '0));
    // enable write never checks for an edge
    send_request(request_of(CMD_WRITE, KIND_ENABLE, BANK_LO, '0, '0, '0));
    send_request(request_of(CMD_READ, KIND_ENABLE, BANK_LO, '0, '0, '0));
    // reserved selectors and the reserved command
    send_request(request_of(CMD_WRITE, KIND_RSVD, BANK_LO, ALL_ONES, '0, '0));
    send_request(request_of(CMD_READ, KIND_RSVD, BANK_LO, '0, '0, '0));
    send_request(request_of(CMD_READ, KIND_RSVD, BANK_HI, '0, '0, '0));
    send_request(request_of(CMD_RSVD, KIND_RSVD, BANK_HI, ALL_ONES, ALL_ONES, ALL_ONES));
    cur_lo = ALL_ONES;
    cur_hi = '0;

    // random part in three idling phases
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_request(random_request());
    end
    req_valid <= 1'b0;

    // drain, then let the last result settle before the verdict
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/eic64_pkg.sv
sv/edge_interrupt_controller_64_top.sv
verif/eic64_irq_checker.sv
verif/edge_interrupt_controller_64_top_tb.sv
